// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of this project.
// No dependencies; take it in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tdps_pkg.sv =====
// Constants shared by the timer period / prescaler pair search block.
// No dependencies.
package tdps_pkg;

  localparam int unsigned CountW             = 32;
  localparam int unsigned OutW               = 16;
  localparam int unsigned DivW               = 8;
  localparam int unsigned CounterWidthDefault = 16;
  localparam int unsigned DivCntW            = $clog2(CountW);

  localparam logic [DivW-1:0]   TolDivReset = 8'd6;
  localparam logic [CountW-1:0] MinTol      = 32'd5;
  localparam logic [CountW-1:0] BoundSat    = 32'hFFFF_FFFF;

endpackage

// ===== rtl/tdps_if.sv =====
// Valid/ready channels of the pair search block: request and response.
// Depends on tdps_pkg for the field widths.
interface tdps_req_if;
  logic                        valid;
  logic                        ready;
  logic [tdps_pkg::CountW-1:0] cycle_count;

  modport source (output valid, output cycle_count, input ready);
  modport sink   (input valid, input cycle_count, output ready);
endinterface

interface tdps_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [tdps_pkg::OutW-1:0] period_value;
  logic [tdps_pkg::OutW-1:0] prescale_value;
  logic                      pair_found;

  modport source (output valid, output period_value, output prescale_value,
                  output pair_found, input ready);
  modport sink   (input valid, input period_value, input prescale_value,
                  input pair_found, output ready);
endinterface

// ===== rtl/timer_divider_pair_search_top.sv =====
// Pair search block: one item in (cycle count), one item out (period, prescaler, found).
// An item goes through the tolerance division and a set-up step, then the search: none for a
// count that fits the counter, otherwise multiplier raises and period steps of the shared
// add/subtract unit and a final check. The done state hands the result to the output register
// (it waits there while the previous result is stalled), and the block goes back to idle
// before the next request is taken. The output register lets a new request in while a
// result still waits.
// Uses tdps_pkg, tdps_if, assert macros.
`include "assert_macros.svh"

module timer_divider_pair_search_top #(
  parameter int unsigned CounterWidth = tdps_pkg::CounterWidthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tdps_pkg::DivW-1:0] cfg_wdata_i,
  tdps_req_if.sink                  req,
  tdps_rsp_if.source                rsp
);

  localparam int unsigned ProdW = 2 * CounterWidth;
  localparam int unsigned WideW = (ProdW > tdps_pkg::CountW + 1) ? ProdW : tdps_pkg::CountW + 1;
  localparam logic [CounterWidth-1:0] MaxV = {CounterWidth{1'b1}};
  localparam logic [WideW-1:0] ClampLimit = WideW'(MaxV) * WideW'(MaxV);
  localparam logic [CounterWidth-1:0] OneV = CounterWidth'(1);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StDivide = 5'b00010,
    StSetup  = 5'b00100,
    StSearch = 5'b01000,
    StDone   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [tdps_pkg::DivW-1:0]    div_q;
  logic [tdps_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic [tdps_pkg::CountW-1:0]  quo_q, quo_d;
  logic [tdps_pkg::DivW-1:0]    rem_q, rem_d;
  logic [tdps_pkg::DivCntW-1:0] step_q, step_d;
  logic [tdps_pkg::CountW:0]    bound_q, bound_d;
  logic [CounterWidth-1:0]      per_q, per_d;
  logic [CounterWidth-1:0]      mul_q, mul_d;
  logic [ProdW-1:0]             prod_q, prod_d;
  logic                         found_q, found_d;

  logic                         rsp_valid_q, rsp_valid_d;
  logic [tdps_pkg::OutW-1:0]    rsp_per_q, rsp_pre_q;
  logic                         rsp_found_q;
  logic                         rsp_load;

  // divide step
  logic [tdps_pkg::DivW-1:0] div_eff;
  logic [tdps_pkg::DivW:0]   rem_sh;
  logic                      rem_ge;
  logic [tdps_pkg::DivW-1:0] rem_nx;

  // set-up
  logic [tdps_pkg::CountW-1:0] tol_adj;
  logic [tdps_pkg::CountW:0]   bound_sum;
  logic                        direct;
  logic                        over;

  // search unit
  logic             below, in_window, sub;
  logic [ProdW-1:0] opnd, prod_nx;

  assign div_eff = (div_q == '0) ? tdps_pkg::DivW'(1) : div_q;
  assign rem_sh  = {rem_q, quo_q[tdps_pkg::CountW-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_eff};
  assign rem_nx  = rem_ge ? tdps_pkg::DivW'(rem_sh - {1'b0, div_eff})
                          : rem_sh[tdps_pkg::DivW-1:0];

  assign tol_adj   = (quo_q <= tdps_pkg::CountW'(1)) ? tdps_pkg::MinTol : quo_q;
  assign bound_sum = {1'b0, cnt_q} + {1'b0, tol_adj};
  assign direct    = ((WideW'(cnt_q) >> CounterWidth) == '0);
  assign over      = WideW'(bound_sum) > ClampLimit;

  // One add/subtract: raise the multiplier (add period) or step the period down
  // (subtract multiplier).
  assign below     = WideW'(prod_q) < WideW'(cnt_q);
  assign in_window = WideW'(prod_q) <= WideW'(bound_q);
  assign sub       = !below;
  assign opnd      = below ? ProdW'(per_q) : ProdW'(mul_q);
  assign prod_nx   = prod_q + (opnd ^ {ProdW{sub}}) + ProdW'(sub);

  assign req.ready = (state_q == StIdle);
  assign rsp_load  = (state_q == StDone) && (!rsp_valid_q || rsp.ready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    bound_d = bound_q;
    per_d   = per_q;
    mul_d   = mul_q;
    prod_d  = prod_q;
    found_d = found_q;
    case (state_q)
      StIdle: begin
        if (req.valid) begin
          cnt_d   = req.cycle_count;
          quo_d   = req.cycle_count;
          rem_d   = '0;
          step_d  = '1;
          state_d = StDivide;
        end
      end
      StDivide: begin
        quo_d  = {quo_q[tdps_pkg::CountW-2:0], rem_ge};
        rem_d  = rem_nx;
        step_d = step_q - tdps_pkg::DivCntW'(1);
        if (step_q == '0) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        bound_d = bound_sum;
        if (over) begin
          bound_d = {1'b0, tdps_pkg::BoundSat};
          cnt_d   = tdps_pkg::CountW'(ClampLimit);
        end
        mul_d = OneV;
        if (direct) begin
          per_d   = CounterWidth'(cnt_q);
          found_d = 1'b1;
          state_d = StDone;
        end else begin
          per_d   = MaxV;
          prod_d  = ProdW'(MaxV);
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (below) begin
          if (mul_q == MaxV) begin
            // multiplier would pass the counter range: no pair for any smaller period
            per_d   = '0;
            mul_d   = OneV;
            found_d = 1'b0;
            state_d = StDone;
          end else begin
            mul_d  = mul_q + OneV;
            prod_d = prod_nx;
          end
        end else if (in_window) begin
          found_d = 1'b1;
          state_d = StDone;
        end else if (per_q == OneV) begin
          per_d   = '0;
          mul_d   = OneV;
          found_d = 1'b0;
          state_d = StDone;
        end else begin
          per_d  = per_q - OneV;
          prod_d = prod_nx;
        end
      end
      StDone: begin
        if (rsp_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_q       <= tdps_pkg::TolDivReset;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        div_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    bound_q <= bound_d;
    per_q   <= per_d;
    mul_q   <= mul_d;
    prod_q  <= prod_d;
    found_q <= found_d;
    if (rsp_load) begin
      rsp_per_q   <= tdps_pkg::OutW'(per_q);
      rsp_pre_q   <= tdps_pkg::OutW'(mul_q - OneV);
      rsp_found_q <= found_q;
    end
  end

  assign rsp.valid          = rsp_valid_q;
  assign rsp.period_value   = rsp_per_q;
  assign rsp.prescale_value = rsp_pre_q;
  assign rsp.pair_found     = rsp_found_q;

  `ASSERT_IMP(a_nopair_zero, clk_i, rst_ni, rsp.valid && !rsp.pair_found, (rsp.period_value == '0) && (rsp.prescale_value == '0), "missing pair must read as zero")
  `ASSERT_IMP(a_search_per_nz, clk_i, rst_ni, state_q == StSearch, per_q != '0, "search period reached zero")
  `ASSERT_NXT(a_accept_divide, clk_i, rst_ni, req.valid && req.ready, state_q == StDivide, "accepted item did not start the division")
  `ASSERT_IMP(a_rsp_from_done, clk_i, rst_ni, $rose(rsp_valid_q), $past(state_q == StDone), "result raised outside the done state")

endmodule

// ===== test/tdps_split_checker.sv =====
// Checker for the timer period / prescaler pair search: predicts each result and compares.
// Depends on tdps_pkg and the tdps_req_if / tdps_rsp_if channel interfaces.
module tdps_split_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tdps_pkg::DivW-1:0] cfg_wdata_i,
  tdps_req_if                       req,
  tdps_rsp_if                       rsp,
  output int                        fail_count_o,
  output int                        pending_o
);
  import tdps_pkg::*;

  localparam logic [63:0] MaxPeriod = (64'd1 << CounterWidthDefault) - 64'd1;
  localparam logic [63:0] ClampLimit = MaxPeriod * MaxPeriod;

  typedef struct packed {
    logic [OutW-1:0] period;
    logic [OutW-1:0] prescale;
    logic            found;
  } split_t;

  split_t          expected_splits[$];
  logic [DivW-1:0] tol_divisor = TolDivReset;

  function automatic split_t split_count(input logic [CountW-1:0] count_in,
                                         input logic [DivW-1:0]   divisor);
    logic [63:0] count;
    logic [63:0] tol;
    logic [63:0] bound;
    logic [63:0] per;
    logic [63:0] mult;
    logic        direct;
    logic        done;
    split_t      res;
    res    = '0;
    count  = 64'(count_in);
    // a zero divisor behaves like one
    tol    = count / ((divisor == '0) ? 64'd1 : 64'(divisor));
    if (tol <= 64'd1) begin
      tol = 64'(MinTol);
    end
    bound  = count + tol;
    direct = (count >> CounterWidthDefault) == 64'd0;
    if (bound > ClampLimit) begin
      bound = 64'(BoundSat);
      count = ClampLimit;
    end
    if (direct) begin
      res.period = count[OutW-1:0];
      res.found  = 1'b1;
    end else begin
      per  = MaxPeriod;
      done = 1'b0;
      while (!done && per != 64'd0) begin
        // smallest multiplier that reaches the count at this period
        mult = (count + per - 64'd1) / per;
        if (mult == 64'd0) begin
          mult = 64'd1;
        end
        if (mult <= MaxPeriod && mult * per <= bound) begin
          res.period   = per[OutW-1:0];
          res.prescale = OutW'(mult - 64'd1);
          res.found    = 1'b1;
          done         = 1'b1;
        end else begin
          per = per - 64'd1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    split_t got;
    split_t want;
    if (!rst_ni) begin
      tol_divisor = TolDivReset;
      expected_splits.delete();
    end else begin
      if (cfg_we_i) begin
        tol_divisor = cfg_wdata_i;
      end
      // pop before push so a result never matches an item taken in the same cycle
      if (rsp.valid && rsp.ready) begin
        got = '{period: rsp.period_value, prescale: rsp.prescale_value,
                found: rsp.pair_found};
        if (expected_splits.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: unexpected item: period %0d prescale %0d found %0b", $time,
                   got.period, got.prescale, got.found);
        end else begin
          want = expected_splits.pop_front();
          if (got !== want) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: mismatch: expected period %0d prescale %0d found %0b, actual period %0d prescale %0d found %0b",
                     $time, want.period, want.prescale, want.found,
                     got.period, got.prescale, got.found);
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_splits.push_back(split_count(req.cycle_count, tol_divisor));
      end
    end
    pending_o = expected_splits.size();
  end

endmodule

// ===== test/tb_timer_divider_pair_search_top.sv =====
// Testbench top for timer_divider_pair_search_top: drives cycle counts and divisor writes.
// Depends on tdps_pkg, the channel interfaces and tdps_split_checker for prediction.
module tb_timer_divider_pair_search_top;
  import tdps_pkg::*;

  localparam int unsigned QuietLimit = 400000;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [DivW-1:0] cfg_wdata_i;
  int              fail_count;
  int              pending_count;
  int              quiet_cycles = 0;
  int              burst_left = 0;
  int unsigned     ready_mode = 0;
  int              ready_mode_left = 0;

  tdps_req_if req_ch ();
  tdps_rsp_if rsp_ch ();

  timer_divider_pair_search_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  tdps_split_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always #10 clk_i = ~clk_i;

  // receiver stalls follow one of four random patterns, picked anew when the current one runs out
  always @(posedge clk_i) begin
    if (ready_mode_left == 0) begin
      ready_mode      <= $urandom_range(0, 3);
      ready_mode_left <= $urandom_range(20, 200);
    end else begin
      ready_mode_left <= ready_mode_left - 1;
    end
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: begin
          rsp_ch.ready <= 1'b1;
        end
        1: begin
          rsp_ch.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        end
        default: begin
          rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_count(input logic [CountW-1:0] count);
    int gap;
    req_ch.cycle_count <= count;
    req_ch.valid       <= 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) begin
      @(posedge clk_i);
    end
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold the sender until every result is back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_divisor(input logic [DivW-1:0] divisor);
    cfg_wdata_i <= divisor;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // keep most counts cheap to search: large counts need many multiplier steps
  function automatic logic [CountW-1:0] random_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      return CountW'($urandom_range(0, 600));
    end else if (sel < 50) begin
      return CountW'($urandom_range(0, 65535));
    end else if (sel < 89) begin
      return CountW'($urandom_range(32'h0010_0000, 32'h0080_0000));
    end else if (sel < 99) begin
      return CountW'($urandom_range(32'h0001_0000, 32'h0010_0000));
    end
    return CountW'($urandom);
  endfunction

  initial begin
    logic [CountW-1:0] corner_counts [16] = '{
      32'd0, 32'd1, 32'd11, 32'd12, 32'd13, 32'h0000_5555, 32'h0000_AAAA, 32'h0000_FFFF,
      32'h0001_0000, 32'h0001_0001, 32'h00FF_FF00, 32'h5555_5555, 32'hAAAA_AAAA,
      32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFF_FFFF
    };
    logic [DivW-1:0] divisor;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_ch.valid       = 1'b0;
    req_ch.cycle_count = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // corners run with the reset divisor
    foreach (corner_counts[i]) begin
      send_count(corner_counts[i]);
    end
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       divisor = 8'd1;
        1:       divisor = 8'd255;
        2:       divisor = 8'd0;
        default: divisor = DivW'($urandom_range(2, 254));
      endcase
      write_divisor(divisor);
      for (int i = 0; i < 230; i++) begin
        send_count(random_count());
        if (i == 115) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
